### sv/rhd_pkg.sv
package rhd_pkg;

  localparam int SAMPLE_DEPTH       = 16;
  localparam int SAMPLE_INTERVAL_MS = 30000;
  localparam int MS_PER_MINUTE      = 60000;
  localparam int PERCENT_MAX        = 100;

  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int FW = $clog2(SAMPLE_DEPTH + 1);
  localparam int VW = 7;

  localparam int THR_W   = 8;
  localparam int MIN_W   = 11;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 11;
  localparam int CNT_W   = 6;
  localparam int PC_W    = 3;

  localparam logic [CFG_IW-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IW-1:0] REG_CLEAR_MIN = 2'd1;

  localparam logic [THR_W-1:0] THR_RESET = 8'd4;
  localparam logic [MIN_W-1:0] MIN_RESET = 11'd10;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_GATE,
    OP_PUSH,
    OP_INIT,
    OP_PRIME,
    OP_WALK,
    OP_DECIDE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_START,
    COND_NOT_TAKEN,
    COND_SHORT,
    COND_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic no_start;
    logic not_taken;
    logic short_fill;
    logic more;
    logic out_busy;
  } flags_t;

  // step numbers of the program
  localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
  localparam logic [PC_W-1:0] PC_DECIDE = 3'd6;
  localparam logic [PC_W-1:0] PC_EMIT   = 3'd7;
  localparam logic [PC_W-1:0] PC_WALK   = 3'd5;
  localparam logic [PC_W-1:0] PC_LAST   = 3'd7;

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    addr_inc = (a == AW'(SAMPLE_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

endpackage

### sv/rhd_ring.sv
module rhd_ring import rhd_pkg::*; (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [VW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [VW-1:0] rdata
);

  logic [VW-1:0] mem [SAMPLE_DEPTH];
  logic [VW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/rhd_seq.sv
module rhd_seq import rhd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ctl_t   ctl
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            jump;

  function automatic ctl_t rom(input logic [PC_W-1:0] a);
    ctl_t w;
    unique case (a)
      3'd0:    w = '{op: OP_WAIT,   cond: COND_NO_START,  target: PC_WAIT};
      3'd1:    w = '{op: OP_GATE,   cond: COND_NOT_TAKEN, target: PC_EMIT};
      3'd2:    w = '{op: OP_PUSH,   cond: COND_NONE,      target: PC_WAIT};
      3'd3:    w = '{op: OP_INIT,   cond: COND_NONE,      target: PC_WAIT};
      3'd4:    w = '{op: OP_PRIME,  cond: COND_SHORT,     target: PC_DECIDE};
      3'd5:    w = '{op: OP_WALK,   cond: COND_MORE,      target: PC_WALK};
      3'd6:    w = '{op: OP_DECIDE, cond: COND_NONE,      target: PC_WAIT};
      default: w = '{op: OP_EMIT,   cond: COND_OUT_BUSY,  target: PC_EMIT};
    endcase
    rom = w;
  endfunction

  assign ctl = rom(pc_r);

  always_comb begin
    unique case (ctl.cond)
      COND_NO_START:  jump = flags.no_start;
      COND_NOT_TAKEN: jump = flags.not_taken;
      COND_SHORT:     jump = flags.short_fill;
      COND_MORE:      jump = flags.more;
      COND_OUT_BUSY:  jump = flags.out_busy;
      default:        jump = 1'b0;
    endcase
    if (jump) begin
      pc_nxt = ctl.target;
    end else if (pc_r == PC_LAST) begin
      pc_nxt = PC_WAIT;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

### sv/rhd_dpath.sv
module rhd_dpath import rhd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl,
  output flags_t            flags,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_valid,
  input  logic [15:0]       in_open_percent,
  input  logic [31:0]       in_time_ms,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              out_sample_taken,
  output logic [CNT_W-1:0]  out_reversal_count,
  output logic              out_hunting,
  output logic [31:0]       out_hunting_since
);

  logic [THR_W-1:0] thr_r;
  logic [MIN_W-1:0] min_r;
  logic [31:0]      quiet_lim_r;

  logic [VW-1:0]    val_r;
  logic [31:0]      now_r;
  logic [AW-1:0]    head_r;
  logic [FW-1:0]    fill_r;
  logic [31:0]      last_time_r;
  logic             hunt_r;
  logic [31:0]      hstart_r;
  logic [31:0]      stable_r;
  logic [CNT_W-1:0] last_rev_r;
  logic             taken_r;

  logic [AW-1:0]    ptr_r;
  logic [FW-1:0]    idx_r;
  logic [VW-1:0]    prev_r;
  logic [CNT_W-1:0] turns_r;
  logic             dir_vld_r;
  logic             dir_up_r;

  logic             ov_r, o_taken_r, o_hunt_r;
  logic [CNT_W-1:0] o_rev_r;
  logic [31:0]      o_since_r;

  logic [AW-1:0]    first;
  logic [AW-1:0]    raddr;
  logic [VW-1:0]    rdata;
  logic             gate_ok;
  logic             d_up;
  logic [VW-1:0]    clamp;

  assign gate_ok = (last_time_r == '0) ||
                   ((now_r - last_time_r) >= 32'(SAMPLE_INTERVAL_MS));
  assign first   = (fill_r < FW'(SAMPLE_DEPTH)) ? '0 : head_r;
  assign raddr   = (ctl.op == OP_INIT) ? first : ptr_r;
  assign d_up    = rdata > prev_r;

  always_comb begin
    if (in_open_percent[15]) begin
      clamp = '0;
    end else if (in_open_percent > 16'(PERCENT_MAX)) begin
      clamp = VW'(PERCENT_MAX);
    end else begin
      clamp = in_open_percent[VW-1:0];
    end
  end

  assign flags.no_start   = !in_valid;
  assign flags.not_taken  = !gate_ok;
  assign flags.short_fill = fill_r < FW'(2);
  assign flags.more       = ({1'b0, idx_r} + 1'b1) < {1'b0, fill_r};
  assign flags.out_busy   = ov_r && out_stall;

  rhd_ring u_ring (
    .clk   (clk),
    .we    (ctl.op == OP_PUSH),
    .waddr (head_r),
    .wdata (val_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  // config registers and the clear time product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      min_r <= MIN_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_THRESHOLD) begin
        thr_r <= cfg_wdata[THR_W-1:0];
      end else if (cfg_index == REG_CLEAR_MIN) begin
        min_r <= cfg_wdata[MIN_W-1:0];
      end
    end
    quiet_lim_r <= 32'(min_r) * 32'(MS_PER_MINUTE);
  end

  // payload working registers
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_WAIT: begin
        if (in_valid) begin
          val_r <= clamp;
          now_r <= in_time_ms;
        end
      end
      OP_INIT: begin
        ptr_r     <= addr_inc(first);
        idx_r     <= FW'(1);
        turns_r   <= '0;
        dir_vld_r <= 1'b0;
        dir_up_r  <= 1'b0;
      end
      OP_PRIME: begin
        prev_r <= rdata;
        ptr_r  <= addr_inc(ptr_r);
      end
      OP_WALK: begin
        prev_r <= rdata;
        ptr_r  <= addr_inc(ptr_r);
        idx_r  <= idx_r + 1'b1;
        if (rdata != prev_r) begin
          if (dir_vld_r && (d_up != dir_up_r)) begin
            turns_r <= turns_r + 1'b1;
          end
          dir_vld_r <= 1'b1;
          dir_up_r  <= d_up;
        end
      end
      default: begin
      end
    endcase
  end

  // detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      last_time_r <= '0;
      hunt_r      <= 1'b0;
      hstart_r    <= '0;
      stable_r    <= '0;
      last_rev_r  <= '0;
      taken_r     <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_GATE: taken_r <= gate_ok;
        OP_PUSH: begin
          head_r      <= addr_inc(head_r);
          last_time_r <= now_r;
          if (fill_r < FW'(SAMPLE_DEPTH)) begin
            fill_r <= fill_r + 1'b1;
          end
        end
        OP_DECIDE: begin
          last_rev_r <= turns_r;
          if ({2'b0, turns_r} >= thr_r) begin
            if (!hunt_r) begin
              hunt_r   <= 1'b1;
              hstart_r <= now_r;
            end
            stable_r <= '0;
          end else if (hunt_r) begin
            if (stable_r == '0) begin
              stable_r <= now_r;
            end else if ((now_r - stable_r) >= quiet_lim_r) begin
              hunt_r   <= 1'b0;
              hstart_r <= '0;
              stable_r <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ctl.op == OP_EMIT && !flags.out_busy) begin
      ov_r <= 1'b1;
    end else if (ov_r && !out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_EMIT && !flags.out_busy) begin
      o_taken_r <= taken_r;
      o_rev_r   <= last_rev_r;
      o_hunt_r  <= hunt_r;
      o_since_r <= hstart_r;
    end
  end

  assign out_valid          = ov_r;
  assign out_sample_taken   = o_taken_r;
  assign out_reversal_count = o_rev_r;
  assign out_hunting        = o_hunt_r;
  assign out_hunting_since  = o_since_r;

endmodule

### sv/regulation_hunting_detector_core.sv
// Regulation hunting detector. Each input word carries a drive opening in
// percent (signed, clamped to 0..100) and a wrapping millisecond time. A word
// is sampled when no sample exists yet or at least 30 s have passed; sampled
// values go into a 16-entry ring, direction reversals are counted oldest
// first, and the hunting flag is raised once the count reaches the
// threshold register and dropped after stable_clear_minutes below it.
// Every input word gives exactly one output word. After a word is taken the
// input stays stalled while the word runs through the program: the gate and
// emit steps if it is gated; if it is sampled, the push, init and prime
// steps, the walk over the ring (skipped while fewer than 2 samples are
// stored) and the decide and emit steps. The walk reads one entry per cycle
// through the single registered read port, over the stored samples (up to
// 16, counted after the push). The wait step that follows takes the next
// word. A finished word waits in the output register while the next one is
// being worked on; the emit step holds as long as that register is still
// full and stalled. Registers: index 0 reversal count threshold, index 1
// stable_clear_minutes; other indexes are ignored.
module regulation_hunting_detector_core import rhd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       in_open_percent,
  input  logic [31:0]       in_time_ms,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_sample_taken,
  output logic [CNT_W-1:0]  out_reversal_count,
  output logic              out_hunting,
  output logic [31:0]       out_hunting_since
);

  ctl_t   ctl;
  flags_t flags;

  // program sequencer: step counter plus control ROM
  rhd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  // datapath: ring, walk registers, detector state, output word
  rhd_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .flags              (flags),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_open_percent    (in_open_percent),
    .in_time_ms         (in_time_ms),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_sample_taken   (out_sample_taken),
    .out_reversal_count (out_reversal_count),
    .out_hunting        (out_hunting),
    .out_hunting_since  (out_hunting_since)
  );

  // a word is taken only in the wait step
  assign in_stall = (ctl.op != OP_WAIT);

`ifndef SYNTHESIS
  // once a word is taken the sequencer leaves the wait step
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  // start time is cleared together with the flag
  a_since_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hunting) |-> (out_hunting_since == '0))
    else $error("hunting_since set while not hunting");

  // a ring of N samples holds at most N-2 reversals
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reversal_count <= CNT_W'(SAMPLE_DEPTH - 2)))
    else $error("reversal count out of range");
`endif

endmodule

### sim/regulation_hunting_detector_core_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the regulation hunting detector core.
// A local tracker mirrors the sample gate, the 16-deep ring, the reversal
// count and the hunting/stable timers; every accepted input word pushes one
// expected verdict, and every accepted output word is checked against the
// oldest one, field by field.
module regulation_hunting_detector_core_tb;
  import rhd_pkg::*;

  localparam int PHASES         = 8;
  localparam int PHASE_WORDS    = 135;
  localparam int DIRECTED_WORDS = 15;
  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake and no config write

  // indexes the block has no register behind; writes there must be dropped
  localparam logic [CFG_IW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IW-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic             taken;
    logic [CNT_W-1:0] reversals;
    logic             hunting;
    logic [31:0]      since;
  } verdict_t;

  typedef struct {
    logic [15:0] pct;
    logic [31:0] tms;
    bit          typed;     // want holds a hand-written verdict
    verdict_t    want;
  } stim_row_t;

  // shapes of the opening trace fed in the random part
  typedef enum logic [1:0] {
    SHAPE_SWING,   // back and forth between two levels: drives hunting
    SHAPE_HOLD,    // flat, often with out-of-range encodings of 0 / 100
    SHAPE_RAMP,    // monotonic: no reversals, lets the flag clear
    SHAPE_WILD     // any 16-bit value
  } shape_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [15:0]       in_open_percent = '0;
  logic [31:0]       in_time_ms = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_sample_taken;
  logic [CNT_W-1:0]  out_reversal_count;
  logic              out_hunting;
  logic [31:0]       out_hunting_since;

  // side info travelling with the word on the input port
  bit                word_typed = 1'b0;
  verdict_t          word_want = '0;

  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;

  verdict_t          verdicts_due[$];
  int                mismatches = 0;
  int                quiet_cycles = 0;

  // tracker state
  logic [VW-1:0]     trk_ring[SAMPLE_DEPTH];
  int                trk_head = 0;
  int                trk_fill = 0;
  logic [31:0]       trk_last_time = '0;
  logic              trk_hunting = 1'b0;
  logic [31:0]       trk_hunt_since = '0;
  logic [31:0]       trk_quiet_since = '0;
  logic [CNT_W-1:0]  trk_reversals = '0;
  logic [THR_W-1:0]  trk_threshold = THR_RESET;
  logic [MIN_W-1:0]  trk_clear_min = MIN_RESET;

  regulation_hunting_detector_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_open_percent    (in_open_percent),
    .in_time_ms         (in_time_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sample_taken   (out_sample_taken),
    .out_reversal_count (out_reversal_count),
    .out_hunting        (out_hunting),
    .out_hunting_since  (out_hunting_since)
  );

  always #5 clk = ~clk;

  // Reversals over the stored samples, oldest first. Flat steps are skipped
  // and do not reset the remembered direction.
  function automatic int count_reversals();
    int first;
    int dir;
    int d;
    int turns;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    first = (trk_fill < SAMPLE_DEPTH) ? 0 : trk_head;
    dir = 0;
    turns = 0;
    for (int i = 1; i < trk_fill; i++) begin
      a = trk_ring[(first + i - 1) % SAMPLE_DEPTH];
      b = trk_ring[(first + i) % SAMPLE_DEPTH];
      if (a != b) begin
        d = (b > a) ? 1 : -1;
        if (dir != 0 && d != dir)
          turns++;
        dir = d;
      end
    end
    return turns;
  endfunction

  // One input word through the tracker; returns the verdict it should give.
  task automatic track_hunting(input logic [15:0] pct, input logic [31:0] now,
                               output verdict_t v);
    logic [31:0]   since_last;
    logic [31:0]   quiet_lim;
    logic [VW-1:0] level;
    v.taken = 1'b0;
    since_last = now - trk_last_time;
    // zero last time means nothing sampled yet
    if (trk_last_time == 32'd0 || since_last >= 32'(SAMPLE_INTERVAL_MS)) begin
      v.taken = 1'b1;
      trk_last_time = now;
      if (pct[15])
        level = '0;
      else if (pct > 16'(PERCENT_MAX))
        level = VW'(PERCENT_MAX);
      else
        level = pct[VW-1:0];
      trk_ring[trk_head] = level;
      trk_head = (trk_head + 1) % SAMPLE_DEPTH;
      if (trk_fill < SAMPLE_DEPTH)
        trk_fill++;
      trk_reversals = CNT_W'(count_reversals());
      quiet_lim = 32'(trk_clear_min) * 32'(MS_PER_MINUTE);
      if (THR_W'(trk_reversals) >= trk_threshold) begin
        if (!trk_hunting) begin
          trk_hunting = 1'b1;
          trk_hunt_since = now;
        end
        trk_quiet_since = '0;
      end else if (trk_hunting) begin
        // zero stable time is "not started"; a start at time zero restarts
        if (trk_quiet_since == 32'd0) begin
          trk_quiet_since = now;
        end else if (now - trk_quiet_since >= quiet_lim) begin
          trk_hunting = 1'b0;
          trk_hunt_since = '0;
          trk_quiet_since = '0;
        end
      end
    end
    v.reversals = trk_reversals;
    v.hunting   = trk_hunting;
    v.since     = trk_hunt_since;
  endtask

  // Result side back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Samples both channels and the config port at the edge, before the
  // edge's own updates land: acceptance is exactly what the block saw.
  always @(posedge clk) begin : verdict_monitor
    verdict_t want;
    verdict_t fresh;
    bit       moved;
    if (rst_n) begin
      moved = cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: trk_threshold = cfg_wdata[THR_W-1:0];
          REG_CLEAR_MIN: trk_clear_min = cfg_wdata[MIN_W-1:0];
          default: ;
        endcase
      end
      // check before pushing: a word leaving now belongs to an older input
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (verdicts_due.size() == 0) begin
          $display("%0t: output word with nothing expected (taken %0b rev %0d hunt %0b since %0d)",
                   $time, out_sample_taken, out_reversal_count, out_hunting,
                   out_hunting_since);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_sample_taken !== want.taken) begin
            $display("%0t: sample_taken expected %0b, got %0b",
                     $time, want.taken, out_sample_taken);
            mismatches++;
          end
          if (out_reversal_count !== want.reversals) begin
            $display("%0t: reversal_count expected %0d, got %0d",
                     $time, want.reversals, out_reversal_count);
            mismatches++;
          end
          if (out_hunting !== want.hunting) begin
            $display("%0t: hunting expected %0b, got %0b",
                     $time, want.hunting, out_hunting);
            mismatches++;
          end
          if (out_hunting_since !== want.since) begin
            $display("%0t: hunting_since expected %0d, got %0d",
                     $time, want.since, out_hunting_since);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        // tracker always advances; hand-written rows replace its verdict
        track_hunting(in_open_percent, in_time_ms, fresh);
        verdicts_due.push_back(word_typed ? word_want : fresh);
      end
      // watchdog: any handshake or config write counts as progress
      if (moved) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("FAIL regulation_hunting_detector_core");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // Present one word, with a random lead-in gap, and hold it until taken.
  task automatic send_word(input logic [15:0] pct, input logic [31:0] tms,
                           input bit typed, input verdict_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_open_percent <= pct;
    in_time_ms      <= tms;
    word_typed      <= typed;
    word_want       <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // Both registers, plus one write to an unused index, on back-to-back edges.
  task automatic load_settings(input logic [THR_W-1:0] thr,
                               input logic [MIN_W-1:0] mins);
    cfg_we    <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_wdata <= {3'($urandom), thr};   // upper bits must be dropped
    @(posedge clk);
    cfg_index <= REG_CLEAR_MIN;
    cfg_wdata <= mins;
    @(posedge clk);
    cfg_index <= $urandom_range(1) ? REG_SPARE_A : REG_SPARE_B;
    cfg_wdata <= CFG_DW'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Every word gives a result, so an empty queue means the block is idle;
  // the extra cycles just let any stray output word show up.
  task automatic wait_drained();
    do @(posedge clk); while (verdicts_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    stim_row_t   directed[DIRECTED_WORDS];
    int          phase_thr[PHASES];
    int          phase_min[PHASES];
    int          idle_send[4];
    int          idle_recv[4];
    shape_t      shape;
    int          seg_left;
    int          level;
    int          level_lo;
    int          level_hi;
    bit          swing_up;
    bit          ramp_up;
    int          roll;
    logic [31:0] clock_ms;
    logic [15:0] pct;
    logic [31:0] tms;

    phase_thr = '{1, 0, 255, 2, 4, 3, 0, 0};
    phase_min = '{0, 1, 1440, 2047, 10, 0, 0, 0};
    idle_send = '{0, 55, 0, 29};
    idle_recv = '{0, 0, 55, 29};

    for (int i = 0; i < SAMPLE_DEPTH; i++)
      trk_ring[i] = '0;

    // Threshold 4, 10 minutes (reset values) throughout this table.
    // first sample after reset: nothing to compare yet
    directed[0]  = '{16'd50,      32'd1000,      1'b1, '{1'b1, 6'd0, 1'b0, 32'd0}};
    // 500 ms later: gated, held state comes back
    directed[1]  = '{16'hFFFF,    32'd1500,      1'b1, '{1'b0, 6'd0, 1'b0, 32'd0}};
    // most negative opening clamps to 0, exactly one interval later
    directed[2]  = '{16'h8000,    32'd31000,     1'b1, '{1'b1, 6'd0, 1'b0, 32'd0}};
    // largest opening clamps to 100: down then up is one reversal
    directed[3]  = '{16'h7FFF,    32'd61000,     1'b1, '{1'b1, 6'd1, 1'b0, 32'd0}};
    directed[4]  = '{16'd101,     32'd91000,     1'b0, '0};   // flat step, skipped
    directed[5]  = '{16'd0,       32'd121000,    1'b0, '0};
    directed[6]  = '{16'd100,     32'd151000,    1'b0, '0};
    // fourth reversal reaches the threshold: hunting starts here
    directed[7]  = '{16'd0,       32'd181000,    1'b1, '{1'b1, 6'd4, 1'b1, 32'd181000}};
    directed[8]  = '{16'd100,     32'd181001,    1'b1, '{1'b0, 6'd4, 1'b1, 32'd181000}};
    // sample at time zero, then anything is taken since zero means unset
    directed[9]  = '{16'd7,       32'd0,         1'b0, '0};
    directed[10] = '{16'd100,     32'd5,         1'b0, '0};
    // across the 32-bit wrap: exactly one interval, then one ms short
    directed[11] = '{16'd50,      32'hFFFF_FFF0, 1'b0, '0};
    directed[12] = '{16'd50,      32'h0000_7520, 1'b0, '0};
    directed[13] = '{16'd60,      32'h0000_EA4F, 1'b0, '0};
    directed[14] = '{16'd101,     32'h0000_EA50, 1'b0, '0};

    phase_thr[6] = $urandom_range(0, 6);
    phase_min[6] = $urandom_range(0, 3);
    phase_thr[7] = $urandom_range(0, 255);
    phase_min[7] = $urandom_range(0, 1440);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_settings(THR_RESET, MIN_RESET);
    for (int i = 0; i < DIRECTED_WORDS; i++)
      send_word(directed[i].pct, directed[i].tms, directed[i].typed, directed[i].want);
    in_valid <= 1'b0;
    wait_drained();

    clock_ms = 32'h0000_EA50;
    seg_left = 0;
    level = 50;
    level_lo = 0;
    level_hi = 100;
    swing_up = 1'b0;
    ramp_up = 1'b1;
    shape = SHAPE_HOLD;

    for (int p = 0; p < PHASES; p++) begin
      load_settings(THR_W'(phase_thr[p]), MIN_W'(phase_min[p]));
      send_idle_pct = idle_send[p % 4];
      recv_stall_pct = idle_recv[p % 4];

      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (seg_left == 0) begin
          roll = $urandom_range(99);
          if (roll < 35) begin
            shape = SHAPE_SWING;
            seg_left = $urandom_range(4, 30);
            level_lo = $urandom_range(0, 60);
            level_hi = level_lo + $urandom_range(1, 40);
          end else if (roll < 65) begin
            shape = SHAPE_HOLD;
            seg_left = $urandom_range(10, 45);
            if ($urandom_range(3) == 0)
              level = $urandom_range(1) ? 0 : PERCENT_MAX;
            else
              level = $urandom_range(0, PERCENT_MAX);
          end else if (roll < 85) begin
            shape = SHAPE_RAMP;
            seg_left = $urandom_range(10, 45);
            ramp_up = $urandom_range(1);
          end else begin
            shape = SHAPE_WILD;
            seg_left = $urandom_range(2, 10);
          end
        end
        seg_left--;

        case (shape)
          SHAPE_SWING: begin
            // mostly alternate; an occasional repeat gives flat steps
            if ($urandom_range(9) < 8)
              swing_up = !swing_up;
            pct = swing_up ? 16'(level_hi) : 16'(level_lo);
          end
          SHAPE_HOLD: begin
            if (level == PERCENT_MAX && $urandom_range(1))
              pct = 16'($urandom_range(PERCENT_MAX + 1, 32767));
            else if (level == 0 && $urandom_range(1))
              pct = 16'h8000 | 16'($urandom);
            else
              pct = 16'(level);
          end
          SHAPE_RAMP: begin
            if (ramp_up)
              level = level + int'($urandom_range(1, 6));
            else
              level = level - int'($urandom_range(1, 6));
            if (level > PERCENT_MAX)
              level = PERCENT_MAX;
            if (level < 0)
              level = 0;
            pct = 16'(level);
          end
          default: pct = 16'($urandom);
        endcase

        // time: mostly one interval (or a bit more) per word, with some
        // early words, jumps, zero times and runs up to the wrap
        roll = $urandom_range(99);
        if (roll < 8) begin
          tms = clock_ms + 32'($urandom_range(0, SAMPLE_INTERVAL_MS - 1));
        end else begin
          if (roll < 11)
            clock_ms = $urandom;
          else if (roll < 12)
            clock_ms = '0;
          else if (roll < 13)
            clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 60000));
          else if ($urandom_range(3) == 0)
            clock_ms = clock_ms + 32'(SAMPLE_INTERVAL_MS);
          else
            clock_ms = clock_ms + 32'(SAMPLE_INTERVAL_MS) + 32'($urandom_range(0, 5000));
          tms = clock_ms;
        end

        send_word(pct, tms, 1'b0, '0);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("PASS regulation_hunting_detector_core");
    end else begin
      $display("%0t: %0d mismatches, %0d words still expected",
               $time, mismatches, verdicts_due.size());
      $display("FAIL regulation_hunting_detector_core");
    end
    $finish;
  end

endmodule

### filelist.f
sv/rhd_pkg.sv
sv/rhd_ring.sv
sv/rhd_seq.sv
sv/rhd_dpath.sv
sv/regulation_hunting_detector_core.sv
sim/regulation_hunting_detector_core_tb.sv
